FILE: sv/rss_pkg.sv
package rss_pkg;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  typedef logic [2:0] pc_t;

  localparam pc_t P_IDLE    = 3'd0;
  localparam pc_t P_RANGE   = 3'd1;
  localparam pc_t P_READ_HI = 3'd2;
  localparam pc_t P_PROBE   = 3'd3;
  localparam pc_t P_LOWER   = 3'd4;

  typedef enum logic [1:0] {
    ASEL_MID,
    ASEL_HI,
    ASEL_LO
  } addr_sel_t;

  typedef enum logic [2:0] {
    C_WAIT,
    C_RANGE,
    C_NEXT,
    C_PROBE,
    C_LOWER
  } cond_t;

  typedef struct packed {
    addr_sel_t asel;
    logic      cap_m;
    cond_t     cond;
    pc_t       next_pc;
    pc_t       jump_pc;
  } ctrl_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    unique case (pc)
      P_IDLE:    w = '{asel: ASEL_MID, cap_m: 1'b0, cond: C_WAIT,
                       next_pc: P_RANGE, jump_pc: P_IDLE};
      P_RANGE:   w = '{asel: ASEL_MID, cap_m: 1'b0, cond: C_RANGE,
                       next_pc: P_READ_HI, jump_pc: P_IDLE};
      P_READ_HI: w = '{asel: ASEL_HI, cap_m: 1'b1, cond: C_NEXT,
                       next_pc: P_PROBE, jump_pc: P_IDLE};
      P_PROBE:   w = '{asel: ASEL_LO, cap_m: 1'b0, cond: C_PROBE,
                       next_pc: P_LOWER, jump_pc: P_RANGE};
      P_LOWER:   w = '{asel: ASEL_MID, cap_m: 1'b0, cond: C_LOWER,
                       next_pc: P_RANGE, jump_pc: P_RANGE};
      default:   w = '{asel: ASEL_MID, cap_m: 1'b0, cond: C_WAIT,
                       next_pc: P_RANGE, jump_pc: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/rss_ram.sv
module rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rotated_sorted_search.sv
// Membership search over a rotated, non-decreasing array of signed words
// (duplicates allowed). func 0 clears the store, 1 appends value, 2 searches
// for value. Clear and append leave busy low. Each step of a search checks
// the range, reads the middle and high-end words and compares them, with an
// extra read of the low end when the middle word is above the high-end word;
// a search that misses ends on a failed range check. The number of steps
// grows toward linear in count over long runs of duplicates. The element
// RAM has a single read port and is read one word per cycle. found
// is valid only while done is high, for exactly one cycle; the receiver
// cannot stall and must take it then. A new item may be accepted in the
// same cycle as done.
module rotated_sorted_search #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [31:0] value,
  output logic               done,
  output logic               found
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rss_pkg::pc_t   pc;
  rss_pkg::ctrl_t cw;

  logic [CW-1:0]                count;
  logic signed [CW:0]           lo;
  logic signed [CW:0]           hi;
  logic signed [DATA_WIDTH-1:0] m;
  logic signed [DATA_WIDTH-1:0] target;
  logic signed [DATA_WIDTH-1:0] key_in;
  logic signed [DATA_WIDTH-1:0] rd;
  logic [DATA_WIDTH-1:0]        rdata;
  logic [CW:0]                  sum;
  logic [CW-1:0]                mid;
  logic [AW-1:0]                raddr;
  logic                         accept;
  logic                         we;

  assign cw     = rss_pkg::ucode(pc);
  assign busy   = (pc != rss_pkg::P_IDLE);
  assign accept = start && !busy;
  assign key_in = DATA_WIDTH'(value);
  assign rd     = $signed(rdata);
  assign sum    = {1'b0, lo[CW-1:0]} + {1'b0, hi[CW-1:0]};
  assign mid    = sum[CW:1];
  assign we     = accept && (func == rss_pkg::FUNC_APPEND) && (count < CW'(DEPTH));

  always_comb begin
    unique case (cw.asel)
      rss_pkg::ASEL_HI: raddr = hi[AW-1:0];
      rss_pkg::ASEL_LO: raddr = lo[AW-1:0];
      default:          raddr = mid[AW-1:0];
    endcase
  end

  rss_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(count[AW-1:0]),
    .wdata(key_in),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= rss_pkg::P_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cw.cap_m) begin
        m <= rd;
      end
      unique case (cw.cond)
        rss_pkg::C_WAIT: begin
          if (accept) begin
            case (func)
              rss_pkg::FUNC_CLEAR: count <= '0;
              rss_pkg::FUNC_APPEND: begin
                if (we) begin
                  count <= count + CW'(1);
                end
              end
              rss_pkg::FUNC_SEARCH: begin
                lo     <= '0;
                hi     <= $signed({1'b0, count} - (CW+1)'(1));
                target <= key_in;
                pc     <= cw.next_pc;
              end
              default: ;
            endcase
          end
        end
        rss_pkg::C_RANGE: begin
          if (lo > hi) begin
            done  <= 1'b1;
            found <= 1'b0;
            pc    <= cw.jump_pc;
          end else begin
            pc <= cw.next_pc;
          end
        end
        rss_pkg::C_NEXT: pc <= cw.next_pc;
        rss_pkg::C_PROBE: begin
          // rd holds the high-end word this step
          if (m == target) begin
            done  <= 1'b1;
            found <= 1'b1;
            pc    <= rss_pkg::P_IDLE;
          end else if (m < rd) begin
            if (target > m && target <= rd) begin
              lo <= $signed({1'b0, mid + CW'(1)});
            end else begin
              hi <= $signed({1'b0, mid});
            end
            pc <= cw.jump_pc;
          end else if (m > rd) begin
            pc <= cw.next_pc;
          end else begin
            hi <= $signed(hi - (CW+1)'(1));
            pc <= cw.jump_pc;
          end
        end
        rss_pkg::C_LOWER: begin
          // rd holds the low-end word this step
          if (target <= m && target >= rd) begin
            hi <= $signed({1'b0, mid});
          end else begin
            lo <= $signed({1'b0, mid + CW'(1)});
          end
          pc <= cw.next_pc;
        end
        default: pc <= rss_pkg::P_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("count changed during a search");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("count above capacity");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && func == rss_pkg::FUNC_SEARCH) |=> busy)
    else $error("search transfer did not start sequencer");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

FILE: tb/rotated_sorted_search_tb.sv
module rotated_sorted_search_tb;

  localparam int DEPTH = 1024;
  localparam int RANDOM_ITEMS = 200;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef int int_q_t[$];

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         func;
  logic signed [31:0] value;
  logic               done;
  logic               found;

  int  elem_mem [DEPTH];
  int  elem_count;
  bit  found_q[$];
  int  mismatches;
  int  items_sent;
  bit  no_idle;

  rotated_sorted_search #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .value(value),
    .done(done),
    .found(found)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // modified binary search over the rotated array
  function automatic bit search_elements(int target);
    int lo, hi, mid, m, h, l;
    lo = 0;
    hi = elem_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      m = elem_mem[mid];
      h = elem_mem[hi];
      if (m == target) return 1'b1;
      if (m < h) begin
        if (target > m && target <= h) lo = mid + 1;
        else hi = mid;
      end else if (m > h) begin
        l = elem_mem[lo];
        if (target <= m && target >= l) hi = mid;
        else lo = mid + 1;
      end else begin
        hi--;
      end
    end
    return 1'b0;
  endfunction

  function automatic void update_model(logic [1:0] f, int v);
    case (f)
      rss_pkg::FUNC_CLEAR: elem_count = 0;
      rss_pkg::FUNC_APPEND: begin
        if (elem_count < DEPTH) begin
          elem_mem[elem_count] = v;
          elem_count++;
        end
      end
      rss_pkg::FUNC_SEARCH: found_q.push_back(search_elements(v));
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge with start still high
  task automatic send_item(logic [1:0] f, int v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    func  <= f;
    value <= v;
    do @(posedge clk); while (busy);
    update_model(f, v);
    items_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (found_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0b", $time, found);
        mismatches++;
      end else begin
        if (found !== found_q[0]) begin
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, found_q[0], found);
          mismatches++;
        end
        void'(found_q.pop_front());
      end
    end
  end

  task automatic load_elements(int_q_t q);
    foreach (q[i]) send_item(rss_pkg::FUNC_APPEND, q[i]);
  endtask

  // sorted then rotated; mode 0 full range, 1 heavy duplicates, 2 moderate
  function automatic int_q_t make_rotated(int n, int mode);
    int_q_t s, r;
    int k, base;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: s.push_back($urandom);
        1: s.push_back(base + $urandom_range(0, 3));
        default: s.push_back($urandom_range(0, 400) - 200);
      endcase
    end
    s.sort();
    k = (n > 0) ? $urandom_range(0, n - 1) : 0;
    for (int i = 0; i < n; i++) r.push_back(s[(i + k) % n]);
    return r;
  endfunction

  task automatic probe_elements(int_q_t q, int m);
    int t;
    for (int i = 0; i < m; i++) begin
      case ($urandom_range(0, 3))
        0, 1: t = (q.size() > 0) ? q[$urandom_range(0, q.size() - 1)] : $urandom;
        2: t = ((q.size() > 0) ? q[$urandom_range(0, q.size() - 1)] : 0)
               + ($urandom_range(0, 1) ? 1 : -1);
        default: t = $urandom;
      endcase
      send_item(rss_pkg::FUNC_SEARCH, t);
    end
  endtask

  task automatic test_empty_store();
    send_item(rss_pkg::FUNC_SEARCH, 0);
    send_item(rss_pkg::FUNC_SEARCH, 32'sh8000_0000);
    send_item(rss_pkg::FUNC_SEARCH, 32'sh7fff_ffff);
  endtask

  task automatic test_extreme_values();
    send_item(rss_pkg::FUNC_CLEAR, 0);
    load_elements('{0, 32'sh7fff_ffff, 32'sh8000_0000, -1});
    send_item(rss_pkg::FUNC_SEARCH, 32'sh8000_0000);
    send_item(rss_pkg::FUNC_SEARCH, 32'sh7fff_ffff);
    send_item(rss_pkg::FUNC_SEARCH, -1);
    send_item(rss_pkg::FUNC_SEARCH, 0);
    send_item(rss_pkg::FUNC_SEARCH, 1);
    send_item(rss_pkg::FUNC_SEARCH, -2);
  endtask

  task automatic test_duplicates();
    send_item(rss_pkg::FUNC_CLEAR, 0);
    load_elements('{5, 5, 5, 5, 5, 5, 5});
    send_item(rss_pkg::FUNC_SEARCH, 5);
    send_item(rss_pkg::FUNC_SEARCH, 6);
    send_item(rss_pkg::FUNC_CLEAR, 0);
    load_elements('{2, 2, 3, 2, 2, 2});
    send_item(rss_pkg::FUNC_SEARCH, 3);
    send_item(rss_pkg::FUNC_SEARCH, 1);
  endtask

  task automatic test_unused_func();
    send_item(rss_pkg::FUNC_CLEAR, 0);
    send_item(rss_pkg::FUNC_APPEND, 10);
    send_item(FUNC_UNUSED, 20);
    send_item(rss_pkg::FUNC_SEARCH, 20);
    send_item(rss_pkg::FUNC_SEARCH, 10);
  endtask

  task automatic test_clear_keeps_words();
    send_item(rss_pkg::FUNC_CLEAR, 0);
    send_item(rss_pkg::FUNC_SEARCH, 10);
    send_item(rss_pkg::FUNC_APPEND, -7);
    send_item(rss_pkg::FUNC_SEARCH, -7);
    send_item(rss_pkg::FUNC_SEARCH, 10);
  endtask

  task automatic test_full_store();
    int_q_t q;
    no_idle = 1'b1;
    send_item(rss_pkg::FUNC_CLEAR, 0);
    for (int i = 0; i < DEPTH; i++) q.push_back(((i + 324) % DEPTH) / 3 * 7 - 1000);
    load_elements(q);
    send_item(rss_pkg::FUNC_APPEND, 32'sh7fff_ffff);
    no_idle = 1'b0;
    send_item(rss_pkg::FUNC_SEARCH, 32'sh7fff_ffff);
    send_item(rss_pkg::FUNC_SEARCH, q[0]);
    send_item(rss_pkg::FUNC_SEARCH, q[DEPTH - 1]);
    send_item(rss_pkg::FUNC_SEARCH, q[DEPTH / 2]);
    send_item(rss_pkg::FUNC_SEARCH, q[5] + 1);
    send_item(rss_pkg::FUNC_SEARCH, -5000);
  endtask

  task automatic test_random_sequences();
    int_q_t q;
    int stop_at, kind, n;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
      case (kind)
        7: begin
          send_item(rss_pkg::FUNC_CLEAR, 0);
          q.delete();
          for (int i = 0; i < n; i++) q.push_back($urandom_range(0, 1) ? $urandom
                                                   : $urandom_range(0, 20));
          load_elements(q);
          probe_elements(q, $urandom_range(1, 8));
        end
        8: begin
          for (int i = 0; i < $urandom_range(4, 16); i++)
            send_item(2'($urandom_range(0, 3)), $urandom);
        end
        9: begin
          q = make_rotated($urandom_range(1, 12), $urandom_range(0, 2));
          load_elements(q);
          probe_elements(q, $urandom_range(1, 6));
        end
        default: begin
          send_item(rss_pkg::FUNC_CLEAR, 0);
          q = make_rotated(n, $urandom_range(0, 2));
          load_elements(q);
          probe_elements(q, $urandom_range(1, 10));
        end
      endcase
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    func       = rss_pkg::FUNC_CLEAR;
    value      = '0;
    elem_count = 0;
    mismatches = 0;
    items_sent = 0;
    no_idle    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_store();
    test_extreme_values();
    test_duplicates();
    test_unused_func();
    test_clear_keeps_words();
    test_full_store();
    test_random_sequences();

    start <= 1'b0;
    while (found_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
